/* rtl/qmdec_pkg.sv */
// Package for the QM binary arithmetic decoder.
// Holds the commands, the controller states, the control structs and the estimation ROM.
// No dependencies.
package qmdec_pkg;

   localparam int FifoDepthDefault = 16;

   localparam logic [16:0] AMin    = 17'h08000;
   localparam logic [5:0]  CtInit  = 6'b110000;
   localparam logic [7:0]  ByteFF  = 8'hFF;
   localparam logic [6:0]  IdxMax  = 7'd113;

   typedef enum logic [1:0] {
      CMD_PUSH    = 2'd0,
      CMD_DECODE  = 2'd1,
      CMD_REPRIME = 2'd2,
      CMD_NONE    = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      BSEL_ZERO,
      BSEL_MEM,
      BSEL_FF
   } bsel_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_NORM,
      S_FREAD,
      S_FGET,
      S_RREAD,
      S_RGET,
      S_DEC1,
      S_DEC2
   } state_type;

   typedef struct packed {
      logic     accept;
      logic     push;
      logic     reprime;
      logic     shift_plain;
      logic     shift_byte;
      bsel_type byte_sel;
      logic     pop;
      logic     latch_marker;
      logic     dec1;
      logic     dec2;
   } ctl_type;

   typedef struct packed {
      logic a_low;
      logic need_byte;
      logic fifo_empty;
      logic marker_set;
      logic rd_is_ff;
      logic rd_is_zero;
      logic out_stall;
   } sts_type;

   function automatic logic [31:0] romv(input logic [15:0] qe, input logic [6:0] lps,
                                        input logic [7:0] mps, input logic sw);
      return {qe, mps, sw, lps};
   endfunction

   // Qe[31:16], next MPS index[15:8], switch[7], next LPS index[6:0]
   function automatic logic [31:0] est_entry(input logic [6:0] idx);
      logic [31:0] e;
      unique case (idx)
         7'd0:   e = romv(16'h5a1d,   7'd1,   8'd1, 1'b1);
         7'd1:   e = romv(16'h2586,  7'd14,   8'd2, 1'b0);
         7'd2:   e = romv(16'h1114,  7'd16,   8'd3, 1'b0);
         7'd3:   e = romv(16'h080b,  7'd18,   8'd4, 1'b0);
         7'd4:   e = romv(16'h03d8,  7'd20,   8'd5, 1'b0);
         7'd5:   e = romv(16'h01da,  7'd23,   8'd6, 1'b0);
         7'd6:   e = romv(16'h00e5,  7'd25,   8'd7, 1'b0);
         7'd7:   e = romv(16'h006f,  7'd28,   8'd8, 1'b0);
         7'd8:   e = romv(16'h0036,  7'd30,   8'd9, 1'b0);
         7'd9:   e = romv(16'h001a,  7'd33,  8'd10, 1'b0);
         7'd10:  e = romv(16'h000d,  7'd35,  8'd11, 1'b0);
         7'd11:  e = romv(16'h0006,   7'd9,  8'd12, 1'b0);
         7'd12:  e = romv(16'h0003,  7'd10,  8'd13, 1'b0);
         7'd13:  e = romv(16'h0001,  7'd12,  8'd13, 1'b0);
         7'd14:  e = romv(16'h5a7f,  7'd15,  8'd15, 1'b1);
         7'd15:  e = romv(16'h3f25,  7'd36,  8'd16, 1'b0);
         7'd16:  e = romv(16'h2cf2,  7'd38,  8'd17, 1'b0);
         7'd17:  e = romv(16'h207c,  7'd39,  8'd18, 1'b0);
         7'd18:  e = romv(16'h17b9,  7'd40,  8'd19, 1'b0);
         7'd19:  e = romv(16'h1182,  7'd42,  8'd20, 1'b0);
         7'd20:  e = romv(16'h0cef,  7'd43,  8'd21, 1'b0);
         7'd21:  e = romv(16'h09a1,  7'd45,  8'd22, 1'b0);
         7'd22:  e = romv(16'h072f,  7'd46,  8'd23, 1'b0);
         7'd23:  e = romv(16'h055c,  7'd48,  8'd24, 1'b0);
         7'd24:  e = romv(16'h0406,  7'd49,  8'd25, 1'b0);
         7'd25:  e = romv(16'h0303,  7'd51,  8'd26, 1'b0);
         7'd26:  e = romv(16'h0240,  7'd52,  8'd27, 1'b0);
         7'd27:  e = romv(16'h01b1,  7'd54,  8'd28, 1'b0);
         7'd28:  e = romv(16'h0144,  7'd56,  8'd29, 1'b0);
         7'd29:  e = romv(16'h00f5,  7'd57,  8'd30, 1'b0);
         7'd30:  e = romv(16'h00b7,  7'd59,  8'd31, 1'b0);
         7'd31:  e = romv(16'h008a,  7'd60,  8'd32, 1'b0);
         7'd32:  e = romv(16'h0068,  7'd62,  8'd33, 1'b0);
         7'd33:  e = romv(16'h004e,  7'd63,  8'd34, 1'b0);
         7'd34:  e = romv(16'h003b,  7'd32,  8'd35, 1'b0);
         7'd35:  e = romv(16'h002c,  7'd33,   8'd9, 1'b0);
         7'd36:  e = romv(16'h5ae1,  7'd37,  8'd37, 1'b1);
         7'd37:  e = romv(16'h484c,  7'd64,  8'd38, 1'b0);
         7'd38:  e = romv(16'h3a0d,  7'd65,  8'd39, 1'b0);
         7'd39:  e = romv(16'h2ef1,  7'd67,  8'd40, 1'b0);
         7'd40:  e = romv(16'h261f,  7'd68,  8'd41, 1'b0);
         7'd41:  e = romv(16'h1f33,  7'd69,  8'd42, 1'b0);
         7'd42:  e = romv(16'h19a8,  7'd70,  8'd43, 1'b0);
         7'd43:  e = romv(16'h1518,  7'd72,  8'd44, 1'b0);
         7'd44:  e = romv(16'h1177,  7'd73,  8'd45, 1'b0);
         7'd45:  e = romv(16'h0e74,  7'd74,  8'd46, 1'b0);
         7'd46:  e = romv(16'h0bfb,  7'd75,  8'd47, 1'b0);
         7'd47:  e = romv(16'h09f8,  7'd77,  8'd48, 1'b0);
         7'd48:  e = romv(16'h0861,  7'd78,  8'd49, 1'b0);
         7'd49:  e = romv(16'h0706,  7'd79,  8'd50, 1'b0);
         7'd50:  e = romv(16'h05cd,  7'd48,  8'd51, 1'b0);
         7'd51:  e = romv(16'h04de,  7'd50,  8'd52, 1'b0);
         7'd52:  e = romv(16'h040f,  7'd50,  8'd53, 1'b0);
         7'd53:  e = romv(16'h0363,  7'd51,  8'd54, 1'b0);
         7'd54:  e = romv(16'h02d4,  7'd52,  8'd55, 1'b0);
         7'd55:  e = romv(16'h025c,  7'd53,  8'd56, 1'b0);
         7'd56:  e = romv(16'h01f8,  7'd54,  8'd57, 1'b0);
         7'd57:  e = romv(16'h01a4,  7'd55,  8'd58, 1'b0);
         7'd58:  e = romv(16'h0160,  7'd56,  8'd59, 1'b0);
         7'd59:  e = romv(16'h0125,  7'd57,  8'd60, 1'b0);
         7'd60:  e = romv(16'h00f6,  7'd58,  8'd61, 1'b0);
         7'd61:  e = romv(16'h00cb,  7'd59,  8'd62, 1'b0);
         7'd62:  e = romv(16'h00ab,  7'd61,  8'd63, 1'b0);
         7'd63:  e = romv(16'h008f,  7'd61,  8'd32, 1'b0);
         7'd64:  e = romv(16'h5b12,  7'd65,  8'd65, 1'b1);
         7'd65:  e = romv(16'h4d04,  7'd80,  8'd66, 1'b0);
         7'd66:  e = romv(16'h412c,  7'd81,  8'd67, 1'b0);
         7'd67:  e = romv(16'h37d8,  7'd82,  8'd68, 1'b0);
         7'd68:  e = romv(16'h2fe8,  7'd83,  8'd69, 1'b0);
         7'd69:  e = romv(16'h293c,  7'd84,  8'd70, 1'b0);
         7'd70:  e = romv(16'h2379,  7'd86,  8'd71, 1'b0);
         7'd71:  e = romv(16'h1edf,  7'd87,  8'd72, 1'b0);
         7'd72:  e = romv(16'h1aa9,  7'd87,  8'd73, 1'b0);
         7'd73:  e = romv(16'h174e,  7'd72,  8'd74, 1'b0);
         7'd74:  e = romv(16'h1424,  7'd72,  8'd75, 1'b0);
         7'd75:  e = romv(16'h119c,  7'd74,  8'd76, 1'b0);
         7'd76:  e = romv(16'h0f6b,  7'd74,  8'd77, 1'b0);
         7'd77:  e = romv(16'h0d51,  7'd75,  8'd78, 1'b0);
         7'd78:  e = romv(16'h0bb6,  7'd77,  8'd79, 1'b0);
         7'd79:  e = romv(16'h0a40,  7'd77,  8'd48, 1'b0);
         7'd80:  e = romv(16'h5832,  7'd80,  8'd81, 1'b1);
         7'd81:  e = romv(16'h4d1c,  7'd88,  8'd82, 1'b0);
         7'd82:  e = romv(16'h438e,  7'd89,  8'd83, 1'b0);
         7'd83:  e = romv(16'h3bdd,  7'd90,  8'd84, 1'b0);
         7'd84:  e = romv(16'h34ee,  7'd91,  8'd85, 1'b0);
         7'd85:  e = romv(16'h2eae,  7'd92,  8'd86, 1'b0);
         7'd86:  e = romv(16'h299a,  7'd93,  8'd87, 1'b0);
         7'd87:  e = romv(16'h2516,  7'd86,  8'd71, 1'b0);
         7'd88:  e = romv(16'h5570,  7'd88,  8'd89, 1'b1);
         7'd89:  e = romv(16'h4ca9,  7'd95,  8'd90, 1'b0);
         7'd90:  e = romv(16'h44d9,  7'd96,  8'd91, 1'b0);
         7'd91:  e = romv(16'h3e22,  7'd97,  8'd92, 1'b0);
         7'd92:  e = romv(16'h3824,  7'd99,  8'd93, 1'b0);
         7'd93:  e = romv(16'h32b4,  7'd99,  8'd94, 1'b0);
         7'd94:  e = romv(16'h2e17,  7'd93,  8'd86, 1'b0);
         7'd95:  e = romv(16'h56a8,  7'd95,  8'd96, 1'b1);
         7'd96:  e = romv(16'h4f46, 7'd101,  8'd97, 1'b0);
         7'd97:  e = romv(16'h47e5, 7'd102,  8'd98, 1'b0);
         7'd98:  e = romv(16'h41cf, 7'd103,  8'd99, 1'b0);
         7'd99:  e = romv(16'h3c3d, 7'd104, 8'd100, 1'b0);
         7'd100: e = romv(16'h375e,  7'd99,  8'd93, 1'b0);
         7'd101: e = romv(16'h5231, 7'd105, 8'd102, 1'b0);
         7'd102: e = romv(16'h4c0f, 7'd106, 8'd103, 1'b0);
         7'd103: e = romv(16'h4639, 7'd107, 8'd104, 1'b0);
         7'd104: e = romv(16'h415e, 7'd103,  8'd99, 1'b0);
         7'd105: e = romv(16'h5627, 7'd105, 8'd106, 1'b1);
         7'd106: e = romv(16'h50e7, 7'd108, 8'd107, 1'b0);
         7'd107: e = romv(16'h4b85, 7'd109, 8'd103, 1'b0);
         7'd108: e = romv(16'h5597, 7'd110, 8'd109, 1'b0);
         7'd109: e = romv(16'h504f, 7'd111, 8'd107, 1'b0);
         7'd110: e = romv(16'h5a10, 7'd110, 8'd111, 1'b1);
         7'd111: e = romv(16'h5522, 7'd112, 8'd109, 1'b0);
         7'd112: e = romv(16'h59eb, 7'd112, 8'd111, 1'b1);
         default: e = romv(16'h5a1d, 7'd113, 8'd113, 1'b0);
      endcase
      return e;
   endfunction

endpackage

/* rtl/qmdec_ctrl.sv */
// Controller state machine of the QM binary arithmetic decoder.
// Sequences word acceptance, renormalization, byte fetch and the decision.
// Depends on qmdec_pkg.
module qmdec_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_command,
   input  qmdec_pkg::sts_type   sts,
   output qmdec_pkg::ctl_type   ctl
);

   qmdec_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qmdec_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      ctl          = '0;
      ctl.byte_sel = qmdec_pkg::BSEL_ZERO;
      unique case (state_ff)
         qmdec_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.accept = 1'b1;
               unique case (qmdec_pkg::command_type'(req_command))
                  qmdec_pkg::CMD_PUSH:    ctl.push = 1'b1;
                  qmdec_pkg::CMD_DECODE:  state_in = qmdec_pkg::S_NORM;
                  qmdec_pkg::CMD_REPRIME: ctl.reprime = 1'b1;
                  default:                ;
               endcase
            end
         end
         qmdec_pkg::S_NORM: begin
            if (!sts.a_low) begin
               state_in = qmdec_pkg::S_DEC1;
            end else if (!sts.need_byte) begin
               ctl.shift_plain = 1'b1;
            end else if (sts.marker_set || sts.fifo_empty) begin
               ctl.shift_byte = 1'b1;
            end else begin
               state_in = qmdec_pkg::S_FREAD;
            end
         end
         qmdec_pkg::S_FREAD: state_in = qmdec_pkg::S_FGET;
         qmdec_pkg::S_FGET: begin
            ctl.pop = 1'b1;
            if (sts.rd_is_ff) begin
               state_in = qmdec_pkg::S_RREAD;
            end else begin
               ctl.shift_byte = 1'b1;
               ctl.byte_sel   = qmdec_pkg::BSEL_MEM;
               state_in       = qmdec_pkg::S_NORM;
            end
         end
         qmdec_pkg::S_RREAD: state_in = qmdec_pkg::S_RGET;
         qmdec_pkg::S_RGET: begin
            if (sts.fifo_empty) begin
               ctl.shift_byte = 1'b1;
               ctl.byte_sel   = qmdec_pkg::BSEL_FF;
               state_in       = qmdec_pkg::S_NORM;
            end else begin
               ctl.pop = 1'b1;
               if (sts.rd_is_ff) begin
                  state_in = qmdec_pkg::S_RREAD;
               end else if (sts.rd_is_zero) begin
                  ctl.shift_byte = 1'b1;
                  ctl.byte_sel   = qmdec_pkg::BSEL_FF;
                  state_in       = qmdec_pkg::S_NORM;
               end else begin
                  ctl.latch_marker = 1'b1;
                  ctl.shift_byte   = 1'b1;
                  state_in         = qmdec_pkg::S_NORM;
               end
            end
         end
         qmdec_pkg::S_DEC1: begin
            ctl.dec1 = 1'b1;
            state_in = qmdec_pkg::S_DEC2;
         end
         qmdec_pkg::S_DEC2: begin
            if (!sts.out_stall) begin
               ctl.dec2 = 1'b1;
               state_in = qmdec_pkg::S_IDLE;
            end
         end
         default: state_in = qmdec_pkg::S_IDLE;
      endcase
   end

endmodule

/* rtl/qmdec_datapath.sv */
// Datapath of the QM binary arithmetic decoder: A, C, CT, marker latch,
// byte FIFO memory, decision logic and result register. Depends on qmdec_pkg.
module qmdec_datapath #(
   parameter int FIFO_DEPTH = qmdec_pkg::FifoDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  qmdec_pkg::ctl_type  ctl,
   output qmdec_pkg::sts_type  sts,
   input  logic [7:0]          req_byte_value,
   input  logic [7:0]          req_context_state,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_decoded_bit,
   output logic [7:0]          rsp_new_context_state,
   output logic                rsp_marker_seen,
   output logic [7:0]          rsp_marker_code
);

   localparam int AW = $clog2(FIFO_DEPTH);
   localparam int FW = $clog2(FIFO_DEPTH + 1);
   localparam logic [AW-1:0] LastAddr = AW'(FIFO_DEPTH - 1);
   localparam logic [AW:0]   DepthW   = (AW + 1)'(FIFO_DEPTH);
   localparam logic [FW-1:0] DepthF   = FW'(FIFO_DEPTH);

   logic [7:0]        fifo_mem [FIFO_DEPTH];
   logic [7:0]        rd_ff;
   logic [AW-1:0]     head_ff, head_in, tail;
   logic [FW-1:0]     fill_ff, fill_in;
   logic [AW:0]       tail_sum;
   logic [16:0]       a_ff, a_in, a_pre;
   logic [31:0]       c_ff, c_in, t_val;
   logic signed [5:0] ct_ff, ct_in, ct7, ct8;
   logic [7:0]        mk_ff, mk_in, byte_val;
   logic [7:0]        ctx_ff;
   logic [15:0]       qe_ff;
   logic [7:0]        nm_ff, nl_ff;
   logic [31:0]       entry;
   logic              full;
   logic              a_lt_qe;
   logic              rv_ff, rv_in;
   logic              bit_ff;
   logic [7:0]        nctx_ff, nctx;
   logic              sv_bit;
   logic              mks_ff;
   logic [7:0]        mkc_ff;

   assign full     = (fill_ff == DepthF);
   assign tail_sum = {1'b0, head_ff} + (AW + 1)'(fill_ff);
   assign tail     = (tail_sum >= DepthW) ? AW'(tail_sum - DepthW) : tail_sum[AW-1:0];

   always_ff @(posedge clock) begin
      rd_ff <= fifo_mem[head_ff];
      if (ctl.push && !full) begin
         fifo_mem[tail] <= req_byte_value;
      end
   end

   assign entry = qmdec_pkg::est_entry((ctx_ff[6:0] > qmdec_pkg::IdxMax) ?
                                       qmdec_pkg::IdxMax : ctx_ff[6:0]);

   always_comb begin
      unique case (ctl.byte_sel)
         qmdec_pkg::BSEL_MEM: byte_val = rd_ff;
         qmdec_pkg::BSEL_FF:  byte_val = qmdec_pkg::ByteFF;
         default:             byte_val = 8'h00;
      endcase
   end

   assign ct7     = ct_ff + 6'sd7;
   assign ct8     = ct_ff + 6'sd8;
   assign t_val   = 32'(a_ff) << ct_ff[2:0];
   assign a_lt_qe = (a_ff < {1'b0, qe_ff});

   always_comb begin
      a_in    = a_ff;
      c_in    = c_ff;
      ct_in   = ct_ff;
      mk_in   = mk_ff;
      head_in = head_ff;
      fill_in = fill_ff;
      a_pre   = a_ff;
      nctx    = ctx_ff;
      sv_bit  = ctx_ff[7];
      if (ctl.reprime) begin
         a_in  = '0;
         c_in  = '0;
         ct_in = qmdec_pkg::CtInit;
         mk_in = '0;
      end
      if (ctl.shift_plain) begin
         ct_in = ct_ff - 6'sd1;
         a_in  = {a_ff[15:0], 1'b0};
      end
      if (ctl.shift_byte) begin
         c_in = {c_ff[23:0], byte_val};
         if (ct7 < 0) begin
            ct_in = ct8;
            if (ct8 == 0) begin
               a_pre = qmdec_pkg::AMin;
            end
         end else begin
            ct_in = ct7;
         end
         a_in = {a_pre[15:0], 1'b0};
      end
      if (ctl.latch_marker) begin
         mk_in = rd_ff;
      end
      if (ctl.pop) begin
         head_in = (head_ff == LastAddr) ? '0 : head_ff + 1'b1;
         fill_in = fill_ff - 1'b1;
      end
      if (ctl.push && !full) begin
         fill_in = fill_ff + 1'b1;
      end
      if (ctl.dec1) begin
         a_in = a_ff - {1'b0, entry[31:16]};
      end
      if (ctl.dec2) begin
         if (c_ff >= t_val) begin
            c_in = c_ff - t_val;
            if (a_lt_qe) begin
               nctx = {ctx_ff[7], 7'b0} ^ nm_ff;
            end else begin
               nctx   = {ctx_ff[7], 7'b0} ^ nl_ff;
               sv_bit = ~ctx_ff[7];
            end
            a_in = {1'b0, qe_ff};
         end else if (a_ff < qmdec_pkg::AMin) begin
            if (a_lt_qe) begin
               nctx   = {ctx_ff[7], 7'b0} ^ nl_ff;
               sv_bit = ~ctx_ff[7];
            end else begin
               nctx = {ctx_ff[7], 7'b0} ^ nm_ff;
            end
         end
      end
      rv_in = rv_ff;
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      if (ctl.dec2) begin
         rv_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff    <= '0;
         c_ff    <= '0;
         ct_ff   <= qmdec_pkg::CtInit;
         mk_ff   <= '0;
         head_ff <= '0;
         fill_ff <= '0;
         rv_ff   <= 1'b0;
      end else begin
         a_ff    <= a_in;
         c_ff    <= c_in;
         ct_ff   <= ct_in;
         mk_ff   <= mk_in;
         head_ff <= head_in;
         fill_ff <= fill_in;
         rv_ff   <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         ctx_ff <= req_context_state;
      end
      if (ctl.dec1) begin
         qe_ff <= entry[31:16];
         nm_ff <= entry[15:8];
         nl_ff <= entry[7:0];
      end
      if (ctl.dec2) begin
         bit_ff  <= sv_bit;
         nctx_ff <= nctx;
         mks_ff  <= (mk_ff != 8'h00);
         mkc_ff  <= mk_ff;
      end
   end

   assign sts.a_low      = (a_ff < qmdec_pkg::AMin);
   assign sts.need_byte  = (ct_ff <= 0);
   assign sts.fifo_empty = (fill_ff == '0);
   assign sts.marker_set = (mk_ff != 8'h00);
   assign sts.rd_is_ff   = (rd_ff == qmdec_pkg::ByteFF);
   assign sts.rd_is_zero = (rd_ff == 8'h00);
   assign sts.out_stall  = rv_ff && !rsp_ready;

   assign rsp_valid             = rv_ff;
   assign rsp_decoded_bit       = bit_ff;
   assign rsp_new_context_state = nctx_ff;
   assign rsp_marker_seen       = mks_ff;
   assign rsp_marker_code       = mkc_ff;

endmodule

/* rtl/qcoder_binary_arith_decoder.sv */
// Top level of the QM binary arithmetic decoder.
// Joins qmdec_ctrl and qmdec_datapath; depends on qmdec_pkg.
//
// Usage:
//   The req_ channel takes one word per handshake: command push appends
//   req_byte_value to the byte FIFO (dropped when full), command re-prime
//   clears A, C and the marker latch and sets CT to its initial value,
//   command decode runs one decision on req_context_state. Only a decode
//   gives a word on the rsp_ channel: the decoded bit, the context byte to
//   store back and the marker latch. Renormalization shifts A one bit per
//   cycle in S_NORM while no byte is needed; each byte pulled from the FIFO
//   passes through the single-ported memory read (S_FREAD, S_FGET), and
//   each 0xFF of a run through a further read (S_RREAD, S_RGET).
//   The result sits in an output register, so new words are accepted while
//   it waits; a second decode holds in its last cycle until the receiver
//   takes the first result. Reset empties the FIFO, clears the coder
//   registers, sets CT to its initial value and drops any pending result.
module qcoder_binary_arith_decoder #(
   parameter int FIFO_DEPTH = qmdec_pkg::FifoDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [7:0] req_byte_value,
   input  logic [7:0] req_context_state,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_decoded_bit,
   output logic [7:0] rsp_new_context_state,
   output logic       rsp_marker_seen,
   output logic [7:0] rsp_marker_code
);

   qmdec_pkg::ctl_type ctl;
   qmdec_pkg::sts_type sts;

   qmdec_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .sts         (sts),
      .ctl         (ctl)
   );

   qmdec_datapath #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .ctl                   (ctl),
      .sts                   (sts),
      .req_byte_value        (req_byte_value),
      .req_context_state     (req_context_state),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_decoded_bit       (rsp_decoded_bit),
      .rsp_new_context_state (rsp_new_context_state),
      .rsp_marker_seen       (rsp_marker_seen),
      .rsp_marker_code       (rsp_marker_code)
   );

endmodule

/* dv/tb_qcoder_binary_arith_decoder.sv */
// Testbench for qcoder_binary_arith_decoder: directed and random push, decode and
// re-prime words, checked against a decision predictor kept in a scoreboard class.
// Depends on qmdec_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb_qcoder_binary_arith_decoder;

   localparam int Depth = qmdec_pkg::FifoDepthDefault;
   localparam int IdleLimit = 5000;

   typedef struct packed {
      logic       bit_out;
      logic [7:0] ctx_out;
      logic       mk_seen;
      logic [7:0] mk_code;
   } decision_type;

   class decision_scoreboard;
      logic [16:0]  a_reg;
      logic [31:0]  c_reg;
      int           ct;
      logic [7:0]   marker;
      logic [7:0]   bytes [Depth];
      int           fill;
      int           head;
      decision_type pending_q [$];
      int           errors;

      function new();
         a_reg = '0;
         c_reg = '0;
         ct = -16;
         marker = '0;
         fill = 0;
         head = 0;
         errors = 0;
      endfunction

      function logic [7:0] pop_byte();
         logic [7:0] b;
         if (marker != 0 || fill == 0) return 8'h00;
         b = bytes[head];
         head = (head + 1) % Depth;
         fill--;
         return b;
      endfunction

      function logic [7:0] code_byte();
         logic [7:0] b;
         if (marker != 0) return 8'h00;
         b = pop_byte();
         if (b != qmdec_pkg::ByteFF) return b;
         do b = pop_byte(); while (b == qmdec_pkg::ByteFF);
         if (b == 0) return qmdec_pkg::ByteFF;
         marker = b;
         return 8'h00;
      endfunction

      function decision_type decide(logic [7:0] ctx);
         decision_type r;
         logic [31:0]  e;
         logic [16:0]  qe;
         logic [7:0]   nm, nl, sv, nctx;
         logic [31:0]  t;
         while (a_reg < qmdec_pkg::AMin) begin
            ct--;
            if (ct < 0) begin
               c_reg = {c_reg[23:0], code_byte()};
               ct += 8;
               if (ct < 0) begin
                  ct++;
                  if (ct == 0) a_reg = qmdec_pkg::AMin;
               end
            end
            a_reg = {a_reg[15:0], 1'b0};
         end
         e = qmdec_pkg::est_entry(ctx[6:0] > qmdec_pkg::IdxMax ? qmdec_pkg::IdxMax
                                                               : ctx[6:0]);
         nl = e[7:0];
         nm = e[15:8];
         qe = {1'b0, e[31:16]};
         sv = ctx;
         nctx = ctx;
         a_reg = a_reg - qe;
         t = 32'(a_reg) << (ct & 7);
         if (c_reg >= t) begin
            c_reg -= t;
            if (a_reg < qe) nctx = (sv & 8'h80) ^ nm;
            else begin
               nctx = (sv & 8'h80) ^ nl;
               sv ^= 8'h80;
            end
            a_reg = qe;
         end else if (a_reg < qmdec_pkg::AMin) begin
            if (a_reg < qe) begin
               nctx = (sv & 8'h80) ^ nl;
               sv ^= 8'h80;
            end else nctx = (sv & 8'h80) ^ nm;
         end
         r.bit_out = sv[7];
         r.ctx_out = nctx;
         r.mk_seen = (marker != 0);
         r.mk_code = marker;
         return r;
      endfunction

      function void note_word(logic [1:0] cmd, logic [7:0] byte_v, logic [7:0] ctx);
         case (cmd)
            qmdec_pkg::CMD_PUSH: if (fill < Depth) begin
               bytes[(head + fill) % Depth] = byte_v;
               fill++;
            end
            qmdec_pkg::CMD_REPRIME: begin
               a_reg = '0;
               c_reg = '0;
               ct = -16;
               marker = '0;
            end
            qmdec_pkg::CMD_DECODE: pending_q.push_back(decide(ctx));
            default: ;
         endcase
      endfunction

      function void check_result(decision_type got);
         decision_type want;
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
         end
         want = pending_q.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display({"decision mismatch: expected bit %b ctx %h mk %b %h,",
                         " got bit %b ctx %h mk %b %h"},
                        want.bit_out, want.ctx_out, want.mk_seen, want.mk_code,
                        got.bit_out, got.ctx_out, got.mk_seen, got.mk_code);
         end
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   logic [1:0] req_command = qmdec_pkg::CMD_NONE;
   logic [7:0] req_byte_value = 0;
   logic [7:0] req_context_state = 0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   logic       rsp_decoded_bit;
   logic [7:0] rsp_new_context_state;
   logic       rsp_marker_seen;
   logic [7:0] rsp_marker_code;

   decision_scoreboard sb = new();
   bit quiet = 0;
   int idle_cycles = 0;
   int rsp_wait = 0;
   int rsp_seen = 0;
   int rsp_drawn = 0;

   qcoder_binary_arith_decoder dut (.*);

   always #5 clock = ~clock;

   function int draw_gap();
      return quiet ? 0 : $urandom_range(0, 9);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result({rsp_decoded_bit, rsp_new_context_state, rsp_marker_seen,
                          rsp_marker_code});
         rsp_seen++;
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver: hold ready low for a drawn stall after each taken word
   always @(negedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (rsp_drawn != rsp_seen) begin
         rsp_drawn = rsp_seen;
         rsp_wait = draw_gap();
         rsp_ready <= (rsp_wait == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_ready <= (rsp_wait == 0);
      end else rsp_ready <= 1;
   end

   task automatic send_word(logic [1:0] cmd, logic [7:0] byte_v, logic [7:0] ctx);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_command = cmd;
      req_byte_value = byte_v;
      req_context_state = ctx;
      req_valid = 1;
      do @(posedge clock); while (!req_ready);
      sb.note_word(cmd, byte_v, ctx);
      @(negedge clock);
   endtask

   task automatic push(logic [7:0] b);
      send_word(qmdec_pkg::CMD_PUSH, b, 8'($urandom));
   endtask

   task automatic decode(logic [7:0] ctx);
      send_word(qmdec_pkg::CMD_DECODE, 8'($urandom), ctx);
   endtask

   initial begin
      int sel;
      logic [7:0] prev;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      decode(8'h00);
      push(8'h12); push(8'hFF); push(8'h00); push(8'hAB);
      decode(8'h7F); decode(8'h80); decode(8'hFF); decode(8'd113); decode(8'd114);
      push(8'hFF); push(8'hFF); push(8'hFF); push(8'hD0);
      decode(8'h0D); decode(8'h8E); decode(8'h40);
      send_word(qmdec_pkg::CMD_NONE, 8'hFF, 8'hFF);
      send_word(qmdec_pkg::CMD_REPRIME, 8'h00, 8'h00);
      for (int i = 0; i < 18; i++) push(8'($urandom));
      decode(8'h01);

      prev = 0;
      for (int i = 0; i < 1550; i++) begin
         if (i % 200 == 0) quiet = ($urandom_range(0, 3) == 0);
         sel = $urandom_range(0, 99);
         if (sb.marker != 0 && sel < 25)
            send_word(qmdec_pkg::CMD_REPRIME, 8'($urandom), 8'($urandom));
         else if (sel < 2) send_word(qmdec_pkg::CMD_NONE, 8'($urandom), 8'($urandom));
         else if (sel < 4) send_word(qmdec_pkg::CMD_REPRIME, 8'($urandom), 8'($urandom));
         else if ((sb.fill < 4 && sel < 80) || sel < 45) begin
            if (prev == qmdec_pkg::ByteFF) begin
               sel = $urandom_range(0, 9);
               prev = sel < 5 ? 8'h00 : sel < 7 ? qmdec_pkg::ByteFF
                                                 : 8'($urandom_range(1, 254));
            end else prev = ($urandom_range(0, 11) == 0) ? qmdec_pkg::ByteFF
                                                         : 8'($urandom);
            push(prev);
         end else decode(8'($urandom));
      end
      req_valid = 0;
      quiet = 0;
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (sb.errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
